>>> rtl/mcmr_pkg.sv
// Shared types and constants for the maze cell merge / relabel unit.
// No dependencies; imported by every rtl module of the block.
package mcmr_pkg;

  // Direction codes of an input item
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_GRID_COLS = 1'b0;
  localparam logic CFG_GRID_ROWS = 1'b1;

  localparam int unsigned CFG_W      = 6;
  localparam int unsigned COORD_W    = 5;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned OUT_LBL_W  = 10;
  localparam int unsigned S_DATA_W   = 16;
  localparam int unsigned M_DATA_W   = 16;
  localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

  // Controller -> datapath commands
  typedef struct packed {
    logic init_step;  // clearing pass: write one entry
    logic load_item;  // capture the accepted input item
    logic eval;       // read data valid: latch the result label
    logic do_merge;   // open wall and cell, latch relabel pair, clear scan counters
    logic scan_step;  // issue one relabel read and advance the scan
    logic load_out;   // move the result into the output register
  } mcmr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic init_last;
    logic merge_ok;
    logic scan_last;
    logic out_free;
  } mcmr_sts_t;

endpackage

>>> rtl/mcmr_ctrl.sv
// Sequencing state machine of the maze cell merge / relabel unit.
// Depends on mcmr_pkg (command and status structs).
module mcmr_ctrl import mcmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mcmr_sts_t sts_i,
  output mcmr_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_READ;
        end
      end
      // labels and wall bits are fetched here, registered at the edge
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.merge_ok) begin
          cmd_o.do_merge = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      // last compare / write-back of the scan pipe
      S_DRAIN: state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

>>> rtl/mcmr_datapath.sv
// Datapath of the maze cell merge / relabel unit: config registers, label
// and wall memories, relabel scan pipe and output register. Uses mcmr_pkg.
module mcmr_datapath import mcmr_pkg::*; #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  input  logic [DIR_W-1:0]     direction_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 merged_o,
  output logic [OUT_LBL_W-1:0] joined_label_o,
  input  mcmr_cmd_t            cmd_i,
  output mcmr_sts_t            sts_o
);

  localparam int unsigned Cells = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned LW    = AW;

  function automatic logic [AW-1:0] cell_idx(input logic [CFG_W-1:0] x,
                                             input logic [CFG_W-1:0] y);
    cell_idx = AW'(32'(y) * MAX_COLS + 32'(x));
  endfunction

  // ---- configuration ----
  logic [CFG_W-1:0] grid_cols_q, grid_rows_q, cols, rows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GRID_RESET;
      grid_rows_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cols = (32'(grid_cols_q) > MAX_COLS) ? CFG_W'(MAX_COLS) : grid_cols_q;
  assign rows = (32'(grid_rows_q) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : grid_rows_q;

  // ---- item registers and neighbor decode ----
  logic [COORD_W-1:0] x_q, y_q;
  logic [DIR_W-1:0]   dir_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      x_q   <= cell_x_i;
      y_q   <= cell_y_i;
      dir_q <= direction_i;
    end
  end

  logic [CFG_W-1:0] xw, yw, nx, ny;
  logic             exists, in_grid, item_ok, horiz;
  logic [AW-1:0]    cur_idx, nb_idx, wall_idx;

  assign xw      = {1'b0, x_q};
  assign yw      = {1'b0, y_q};
  assign in_grid = (xw < cols) && (yw < rows);
  assign horiz   = dir_q[1];

  always_comb begin
    nx = xw;
    ny = yw;
    unique case (dir_q)
      DIR_UP: begin
        exists = (yw != '0);
        ny     = yw - CFG_W'(1);
      end
      DIR_DOWN: begin
        exists = (yw + CFG_W'(1)) < rows;
        ny     = yw + CFG_W'(1);
      end
      DIR_RIGHT: begin
        exists = (xw + CFG_W'(1)) < cols;
        nx     = xw + CFG_W'(1);
      end
      DIR_LEFT: begin
        exists = (xw != '0);
        nx     = xw - CFG_W'(1);
      end
      default: exists = 1'b0;
    endcase
  end

  assign item_ok  = in_grid && exists;
  assign cur_idx  = cell_idx(xw, yw);
  assign nb_idx   = cell_idx(nx, ny);
  // walls are stored on the upper / left cell of each pair (the lower index)
  assign wall_idx = (dir_q == DIR_UP || dir_q == DIR_LEFT) ? nb_idx : cur_idx;

  // ---- clearing pass counter ----
  logic [AW-1:0] init_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
    end else if (cmd_i.init_step) begin
      init_cnt_q <= init_cnt_q + AW'(1);
    end
  end

  // ---- relabel scan ----
  logic [CFG_W-1:0] sx_q, sy_q;
  logic [AW-1:0]    scan_addr, pipe_addr_q;
  logic             pipe_v_q, scan_last;
  logic [LW-1:0]    from_q, to_q;

  assign scan_addr = cell_idx(sx_q, sy_q);
  assign scan_last = (sx_q == cols - CFG_W'(1)) && (sy_q == rows - CFG_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_merge) begin
      sx_q <= '0;
      sy_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (sx_q == cols - CFG_W'(1)) begin
        sx_q <= '0;
        sy_q <= sy_q + CFG_W'(1);
      end else begin
        sx_q <= sx_q + CFG_W'(1);
      end
    end
    pipe_addr_q <= scan_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q <= 1'b0;
    end else begin
      pipe_v_q <= cmd_i.scan_step;
    end
  end

  // ---- label memory: one write, two registered reads ----
  logic [LW-1:0] label_mem [Cells];
  logic [LW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] addr_a;

  assign addr_a = cmd_i.scan_step ? scan_addr : cur_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      label_mem[init_cnt_q] <= LW'(init_cnt_q);
    end else if (pipe_v_q && (rd_a_q == from_q)) begin
      label_mem[pipe_addr_q] <= to_q;
    end
    rd_a_q <= label_mem[addr_a];
    rd_b_q <= label_mem[nb_idx];
  end

  // ---- wall and open-cell memories ----
  logic right_mem [Cells];
  logic down_mem  [Cells];
  logic open_mem  [Cells];
  logic right_rd_q, down_rd_q, wall_open;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      right_mem[init_cnt_q] <= 1'b0;
    end else if (cmd_i.do_merge && horiz) begin
      right_mem[wall_idx] <= 1'b1;
    end
    right_rd_q <= right_mem[wall_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      down_mem[init_cnt_q] <= 1'b0;
    end else if (cmd_i.do_merge && !horiz) begin
      down_mem[wall_idx] <= 1'b1;
    end
    down_rd_q <= down_mem[wall_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      open_mem[init_cnt_q] <= 1'b0;
    end else if (cmd_i.do_merge) begin
      open_mem[cur_idx] <= 1'b1;
    end
  end

  assign wall_open = horiz ? right_rd_q : down_rd_q;

  // ---- merge decision and result ----
  logic                 merge_ok, res_merged_q;
  logic [OUT_LBL_W-1:0] res_label_q;

  assign merge_ok = item_ok && !wall_open && (rd_a_q != rd_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      res_merged_q <= merge_ok;
      res_label_q  <= item_ok ? OUT_LBL_W'(rd_b_q) : '0;
    end
    if (cmd_i.do_merge) begin
      from_q <= rd_a_q;
      to_q   <= rd_b_q;
    end
  end

  // ---- output register ----
  logic                 out_v_q, out_merged_q;
  logic [OUT_LBL_W-1:0] out_label_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_merged_q <= res_merged_q;
      out_label_q  <= res_label_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign merged_o       = out_merged_q;
  assign joined_label_o = out_label_q;

  assign sts_o.init_last = (init_cnt_q == AW'(Cells - 1));
  assign sts_o.merge_ok  = merge_ok;
  assign sts_o.scan_last = scan_last;
  assign sts_o.out_free  = !out_v_q || out_ready_i;

endmodule

>>> rtl/maze_cell_merge_relabel_unit.sv
// Top level of the maze cell merge / relabel unit.
// Depends on mcmr_pkg, mcmr_ctrl and mcmr_datapath.
//
// Kruskal-style maze carving. Each input item names a cell and a direction;
// if the neighbor lies in the grid in use, the wall between is closed and
// the two set labels differ, every in-grid cell with the current cell's label
// takes the neighbor's label, the wall and the cell are opened, and the
// result item reports merged=1. Every input item yields exactly one result.
// Channels: s_axis_* takes input items, m_axis_* delivers results, cfg_*
// writes grid_cols (index 0) and grid_rows (index 1); the user must do so
// only while the unit is idle, which the block does not enforce.
// Timing: one item at a time. The relabel scan reads one label memory
// entry per cycle, with a compare/write-back stage behind. The result is
// loaded once the output register is free; the next item can be accepted
// in the cycle after the result is loaded.
// Reset: all labels set to the cell index and all walls closed by a clearing
// pass over all MAX_COLS*MAX_ROWS cells (1024 at defaults); s_axis_tready stays
// low during it. Config writes are taken at any time.
// Stall: the result sits in an output register; the next item may be
// accepted while it waits, and that item's result is held back until the
// register is free.
module maze_cell_merge_relabel_unit import mcmr_pkg::*; #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // [4:0] cell_x, [9:5] cell_y, [11:10] direction
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata    // [0] merged, [10:1] joined_label
);

  mcmr_cmd_t            cmd;
  mcmr_sts_t            sts;
  logic                 merged;
  logic [OUT_LBL_W-1:0] joined_label;

  mcmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcmr_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cell_x_i       (s_axis_tdata[4:0]),
    .cell_y_i       (s_axis_tdata[9:5]),
    .direction_i    (s_axis_tdata[11:10]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .merged_o       (merged),
    .joined_label_o (joined_label),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  // upper tdata bits are padding
  assign m_axis_tdata = {(M_DATA_W - OUT_LBL_W - 1)'(0), joined_label, merged};

endmodule
